FILE: hdl/heightmap_edge_taper_loader_assert.svh
// Assertion macros shared by the heightmap edge taper loader RTL
`ifndef HEIGHTMAP_EDGE_TAPER_LOADER_ASSERT_SVH
`define HEIGHTMAP_EDGE_TAPER_LOADER_ASSERT_SVH

// implication checked at every clock edge outside reset
`define HMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition that must never hold outside reset
`define HMT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: hdl/hmt_pkg.sv
// Shared types and constants of the heightmap edge taper loader
package hmt_pkg;

  localparam int MAX_GRID = 4096;
  localparam int N_W      = 13;
  localparam int C_W      = 12;
  localparam int S_W      = 16;
  localparam int CFG_A_W  = 2;
  localparam int OUT_D_W  = 72;

  localparam logic signed [S_W-1:0] H_MIN = 16'sh8000;
  localparam logic signed [S_W-1:0] H_MAX = 16'sh7fff;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_GRID_SIZE  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_FOLD_WIDTH = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_LOAD
  } hmt_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic mul;
    logic div_init;
    logic div_step;
    logic load;
  } hmt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
    logic out_full;
  } hmt_sts_t;

endpackage

FILE: hdl/hmt_ctrl.sv
// Controller state machine of the heightmap edge taper loader
module hmt_ctrl import hmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  hmt_sts_t sts,
  output hmt_cmd_t cmd
);

  hmt_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_last) state_nxt = ST_LOAD;
      ST_LOAD:  if (!sts.out_full) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_MUL:   cmd.mul = 1'b1;
      ST_DINIT: cmd.div_init = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_LOAD:  cmd.load = !sts.out_full;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: hdl/hmt_dp.sv
// Datapath: counters, taper factors, multipliers, divider, output register
module hmt_dp import hmt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [N_W-1:0]     cfg_wdata,
  input  logic [S_W-1:0]     in_sample,
  input  hmt_cmd_t           cmd,
  output hmt_sts_t           sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_D_W-1:0] out_tdata,
  output logic               out_tlast
);

  `include "heightmap_edge_taper_loader_assert.svh"

  logic [N_W-1:0] grid_r;
  logic [C_W-1:0] fold_r;
  logic [C_W-1:0] row_r, col_r;
  logic signed [S_W-1:0] max_r, min_r;

  logic [S_W-1:0] v_r;
  logic [C_W-1:0] ar_r, ac_r, f_r;
  logic [C_W-1:0] scol_r, srow_r;
  logic           done_r, restart_r;
  logic [2*C_W-1:0] prod_r, fsq_r;
  logic [39:0]    rem_r;
  logic [38:0]    dsh_r;
  logic [S_W-1:0] q_r;
  logic [3:0]     cnt_r;

  logic               ovalid_r, odone_r;
  logic [C_W-1:0]     ocol_r, orow_r;
  logic signed [S_W-1:0] oh_r, omax_r, omin_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= N_W'(256);
      fold_r <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_GRID_SIZE:  grid_r <= cfg_wdata;
        REG_FOLD_WIDTH: fold_r <= cfg_wdata[C_W-1:0];
        default: ;
      endcase
    end
  end

  // effective size and position of the incoming sample
  logic [N_W-1:0] n, nm1;
  logic           restart, done, col_end;
  logic [C_W-1:0] cr, cc;
  logic [N_W-1:0] fz;
  always_comb begin
    if (grid_r == '0) n = N_W'(1);
    else if (grid_r > N_W'(MAX_GRID)) n = N_W'(MAX_GRID);
    else n = grid_r;
    nm1     = n - N_W'(1);
    restart = ({1'b0, row_r} >= n) || ({1'b0, col_r} >= n);
    cr      = restart ? '0 : row_r;
    cc      = restart ? '0 : col_r;
    col_end = ({1'b0, cc} == nm1);
    done    = col_end && ({1'b0, cr} == nm1);
    fz      = {1'b0, fold_r};
  end

  function automatic logic [C_W-1:0] taper(input logic [C_W-1:0] c,
                                           input logic [N_W-1:0] nn,
                                           input logic [C_W-1:0] f);
    logic [N_W-1:0] sum;
    logic [N_W-1:0] far;
    sum = {1'b0, c} + {1'b0, f};
    far = nn - N_W'(1) - {1'b0, c};
    if (c < f) taper = c;
    else if (sum > nn) taper = far[C_W-1:0];
    else taper = f;
  endfunction

  // grid counters and input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.take) begin
      if (done) begin
        row_r <= '0;
        col_r <= '0;
      end else if (col_end) begin
        row_r <= cr + C_W'(1);
        col_r <= '0;
      end else begin
        row_r <= cr;
        col_r <= cc + C_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      v_r       <= in_sample;
      scol_r    <= cc;
      srow_r    <= nm1[C_W-1:0] - cr;
      done_r    <= done;
      restart_r <= restart;
      if (fz == '0) begin
        // no taper: unit factors over a unit divisor
        ar_r <= C_W'(1);
        ac_r <= C_W'(1);
        f_r  <= C_W'(1);
      end else begin
        ar_r <= taper(cr, n, fold_r);
        ac_r <= taper(cc, n, fold_r);
        f_r  <= fold_r;
      end
    end
  end

  // factor product and squared border width
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= (2*C_W)'(ar_r) * (2*C_W)'(ac_r);
      fsq_r  <= (2*C_W)'(f_r) * (2*C_W)'(f_r);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [39:0] diff;
  logic        ge;
  assign ge   = rem_r >= {1'b0, dsh_r};
  assign diff = rem_r - {1'b0, dsh_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= 40'(prod_r) * 40'(v_r);
      dsh_r <= {fsq_r, 15'd0};
      q_r   <= '0;
      cnt_r <= 4'd15;
    end else if (cmd.div_step) begin
      if (ge) rem_r <= diff;
      q_r   <= {q_r[S_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 4'd1;
    end
  end

  assign sts.div_last = (cnt_r == 4'd0);
  assign sts.out_full = ovalid_r && !out_tready;

  // height and running extremes
  logic signed [S_W-1:0] h, bmax, bmin, nmax, nmin;
  always_comb begin
    h    = {~q_r[S_W-1], q_r[S_W-2:0]};
    bmax = restart_r ? H_MIN : max_r;
    bmin = restart_r ? H_MAX : min_r;
    nmax = (h > bmax) ? h : bmax;
    nmin = (h < bmin) ? h : bmin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= H_MIN;
      min_r <= H_MAX;
    end else if (cmd.load) begin
      max_r <= done_r ? H_MIN : nmax;
      min_r <= done_r ? H_MAX : nmin;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ocol_r  <= scol_r;
      orow_r  <= srow_r;
      oh_r    <= h;
      omax_r  <= nmax;
      omin_r  <= nmin;
      odone_r <= done_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {omin_r, omax_r, oh_r, orow_r, ocol_r};
  assign out_tlast  = odone_r;

  `HMT_ASSERT_IMP(a_ext_order, ovalid_r, (omax_r >= oh_r) && (omin_r <= oh_r))
  `HMT_ASSERT_NEVER(a_load_full, cmd.load && sts.out_full)
  `HMT_ASSERT_NEVER(a_take_load, cmd.take && cmd.load)
  `HMT_ASSERT_IMP(a_div_len, cmd.div_init, ##16 sts.div_last)

endmodule

FILE: hdl/heightmap_edge_taper_loader.sv
// Top level of the heightmap edge taper loader
//
// Input stream: one 16-bit unsigned grey sample per transaction, row-major
// over a square grid of grid_size by grid_size samples.
// Output stream: one transaction per sample carrying the row-mirrored store
// address, the tapered signed height and the running max/min of the grid;
// tlast marks the last sample of a grid.
// Configuration: cfg_wen writes cfg_wdata to register cfg_addr (0 grid_size,
// 1 fold_width) at a clock edge; user must write only while idle (not enforced).
// From acceptance to a loaded result, each sample passes through capture,
// two multiplies, divider setup and a restoring divider producing one
// quotient bit a cycle. A new sample is accepted only once the last is loaded.
// The result sits in an output register, so the next sample is accepted
// while it waits; a stalled receiver holds the pipe only at the final
// load step. Reset (rst_n low, synchronous) clears the counters, the
// extremes and the output valid, and restores grid_size 256, fold_width 0.
module heightmap_edge_taper_loader import hmt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [N_W-1:0]     cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [S_W-1:0]     in_tdata,   // sample
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_D_W-1:0] out_tdata,  // store_col, store_row, height, run_max, run_min
  output logic               out_tlast   // grid_done
);

  hmt_cmd_t cmd;
  hmt_sts_t sts;

  hmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hmt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/heightmap_edge_taper_loader_tb.sv
// Self-checking testbench for the heightmap edge taper loader: directed table plus random grids
module heightmap_edge_taper_loader_tb import hmt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // result fields of one transaction
  typedef struct {
    logic [C_W-1:0]        col;
    logic [C_W-1:0]        row;
    logic signed [S_W-1:0] height;
    logic signed [S_W-1:0] hmax;
    logic signed [S_W-1:0] hmin;
    logic                  last;
  } taper_res_t;

  // one row of the directed table; has_exp marks a typed-in expectation
  typedef struct {
    logic        is_cfg;
    logic [1:0]  addr;
    int          value;
    logic        has_exp;
    int          exp_height;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wen;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [N_W-1:0]     cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [S_W-1:0]     in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_D_W-1:0] out_tdata;
  logic               out_tlast;

  heightmap_edge_taper_loader dut (.*);

  // predictor state
  int unsigned pr_size, pr_fold, pr_row, pr_col;
  int          pr_max, pr_min;
  taper_res_t  expected_q[$];
  int          typed_q[$];   // typed-in height per result, or a flag for none
  localparam int NO_TYPED = 100000;
  int          fail_cnt;
  longint      cyc = 0;
  bit          quiet, hold_long;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // give up at a generous limit (allowing for every item plus stalls)
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 400000) begin
      $display("heightmap_edge_taper_loader verification failed");
      $finish;
    end
  end

  function automatic int unsigned taper_axis(int unsigned c, int unsigned n, int unsigned f);
    if (c < f) return c;
    if (c + f > n) return n - 1 - c;
    return f;
  endfunction

  // works out the result of one sample and advances the grid counters
  function automatic taper_res_t taper_predict(logic [S_W-1:0] s);
    taper_res_t r;
    int unsigned n;
    longint unsigned sc;
    int h;
    n = (pr_size == 0) ? 1 : (pr_size > MAX_GRID ? MAX_GRID : pr_size);
    if (pr_row >= n || pr_col >= n) begin
      pr_row = 0; pr_col = 0; pr_max = -32768; pr_min = 32767;
    end
    if (pr_fold == 0) sc = s;
    else sc = (longint'(s) * taper_axis(pr_row, n, pr_fold) * taper_axis(pr_col, n, pr_fold))
              / (longint'(pr_fold) * pr_fold);
    h = int'(sc) - 32768;
    if (h > pr_max) pr_max = h;
    if (h < pr_min) pr_min = h;
    r.col = pr_col; r.row = n - 1 - pr_row; r.height = h;
    r.hmax = pr_max; r.hmin = pr_min;
    r.last = (pr_row == n - 1) && (pr_col == n - 1);
    if (r.last) begin
      pr_row = 0; pr_col = 0; pr_max = -32768; pr_min = 32767;
    end else if (pr_col == n - 1) begin
      pr_col = 0; pr_row++;
    end else pr_col++;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] a, int v);
    cfg_wen <= 1; cfg_addr <= a; cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 0;
    if (a == REG_GRID_SIZE) pr_size = v & 16'h1fff;
    else if (a == REG_FOLD_WIDTH) pr_fold = v & 12'hfff;
    @(negedge clk);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic send_sample(logic [S_W-1:0] s, int typed);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1; in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(taper_predict(s));
    typed_q.push_back(typed);
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_tready <= 0;
        repeat (300) @(negedge clk);
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  // checker of each result transaction
  always @(posedge clk) begin
    taper_res_t e;
    int t;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        t = typed_q.pop_front();
        if (t != NO_TYPED && e.height != t) begin
          $error("table height: expected %0d predicted %0d", t, e.height);
          fail_cnt++;
        end
        if (out_tdata[11:0] !== e.col) begin
          $error("store_col: expected %0d actual %0d", e.col, out_tdata[11:0]); fail_cnt++;
        end
        if (out_tdata[23:12] !== e.row) begin
          $error("store_row: expected %0d actual %0d", e.row, out_tdata[23:12]); fail_cnt++;
        end
        if (out_tdata[39:24] !== e.height) begin
          $error("height: expected %0d actual %0d", e.height,
                 $signed(out_tdata[39:24])); fail_cnt++;
        end
        if (out_tdata[55:40] !== e.hmax) begin
          $error("run_max: expected %0d actual %0d", e.hmax,
                 $signed(out_tdata[55:40])); fail_cnt++;
        end
        if (out_tdata[71:56] !== e.hmin) begin
          $error("run_min: expected %0d actual %0d", e.hmin,
                 $signed(out_tdata[71:56])); fail_cnt++;
        end
        if (out_tlast !== e.last) begin
          $error("grid_done: expected %0d actual %0d", e.last, out_tlast); fail_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t tbl[$];
    int sizes[$];
    int n, f, cnt, k;
    bit held;
    rst_n = 0; cfg_wen = 0; cfg_addr = 0; cfg_wdata = 0;
    in_tvalid = 0; in_tdata = 0;
    pr_size = 256; pr_fold = 0; pr_row = 0; pr_col = 0;
    pr_max = -32768; pr_min = 32767;
    fail_cnt = 0; quiet = 0; hold_long = 0; held = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: taper off extremes, then size 3 fold 1, wide border, odd sizes
    tbl = '{
      '{0, 0, 16'h0000, 1, -32768}, '{0, 0, 16'hffff, 1, 32767},
      '{0, 0, 16'h8000, 1, 0},      '{0, 0, 16'h5555, 0, 0},
      '{1, REG_GRID_SIZE, 3, 0, 0}, '{1, REG_FOLD_WIDTH, 1, 0, 0},
      '{0, 0, 16'hffff, 1, -32768}, '{0, 0, 16'hffff, 0, 0}, '{0, 0, 16'hffff, 0, 0},
      '{0, 0, 16'hffff, 0, 0},      '{0, 0, 16'hffff, 1, 32767}, '{0, 0, 16'haaaa, 0, 0},
      '{0, 0, 16'h1234, 0, 0},      '{0, 0, 16'hffff, 0, 0}, '{0, 0, 16'h0001, 0, 0},
      '{1, REG_FOLD_WIDTH, 2048, 0, 0}, '{1, REG_GRID_SIZE, 0, 0, 0},
      '{0, 0, 16'hffff, 1, -32768}, '{1, REG_GRID_SIZE, 8191, 0, 0},
      '{0, 0, 16'hc3c3, 0, 0},      '{1, 2'd3, 5, 0, 0}, '{0, 0, 16'h7e7e, 0, 0},
      '{1, REG_GRID_SIZE, 2, 0, 0}, '{0, 0, 16'hffff, 0, 0}
    };
    foreach (tbl[i]) begin
      if (tbl[i].is_cfg) begin
        drain();
        write_reg(tbl[i].addr, tbl[i].value);
      end else send_sample(tbl[i].value, tbl[i].has_exp ? tbl[i].exp_height : NO_TYPED);
    end

    // random grids, mostly small; size 4095 runs only a partial grid before the next size change
    cnt = 0;
    sizes = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 4095};
    while (cnt < 800) begin
      n = sizes[$urandom_range(0, sizes.size() - 1)];
      case ($urandom_range(0, 4))
        0: f = 0;
        1: f = n;
        2: f = 2048;
        default: f = $urandom_range(1, (n < 2048) ? n : 2048);
      endcase
      drain();
      write_reg(REG_GRID_SIZE, n);
      write_reg(REG_FOLD_WIDTH, f);
      k = (n > 12) ? 40 : n * n * $urandom_range(1, 2) + $urandom_range(0, 2);
      // one long receiver hold-off over a run long enough to fill the block
      if (cnt > 100 && !held && k > 2) begin
        hold_long = 1;
        held = 1;
      end
      if (cnt > 700) quiet = 1;
      repeat (k) begin
        send_sample($urandom_range(0, 65535), NO_TYPED);
        cnt++;
      end
    end
    drain();
    if (fail_cnt == 0 && expected_q.size() == 0)
      $display("heightmap_edge_taper_loader verification clean");
    else
      $display("heightmap_edge_taper_loader verification failed");
    $finish;
  end
endmodule
